// ===== hw/rtl/drawing_text_unescape_core_macros.svh =====
// Assertion macros shared by the drawing text unescape RTL.
`ifndef DRAWING_TEXT_UNESCAPE_CORE_MACROS_SVH
`define DRAWING_TEXT_UNESCAPE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DTU_ASSERT_IMPLY(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("dtu: implication check failed");
`define DTU_ASSERT_NEXT(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("dtu: next-cycle check failed");
`else
`define DTU_ASSERT_IMPLY(name, ck, rn, a, c)
`define DTU_ASSERT_NEXT(name, ck, rn, a, c)
`endif
`endif

// ===== hw/rtl/dtu_pkg.sv =====
// Types and character constants shared by the drawing text unescape block.
`default_nettype none
package dtu_pkg;
    localparam int QDEPTH = 4;
    localparam int ODEPTH = 4;

    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_S = 8'h53;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // Pass-one output for one input byte: up to three bytes and the end flag.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n;
        logic            last;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } bundle_beat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dtu_front.sv =====
// Pass one: caret controls and percent codes, one input byte per cycle while the queue is not full.
`default_nettype none
module dtu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dtu_pkg::in_item_t     in_data,
    input  logic                  mtext,
    input  logic                  q_full,
    output logic                  full,
    output dtu_pkg::bundle_beat_t q_wr
);
    import dtu_pkg::*;

    localparam logic [7:0] SYM_DIA0 = 8'hE2;
    localparam logic [7:0] SYM_DIA1 = 8'h8C;
    localparam logic [7:0] SYM_DIA2 = 8'h80;
    localparam logic [7:0] SYM_LEAD = 8'hC2;
    localparam logic [7:0] SYM_DEG  = 8'hB0;
    localparam logic [7:0] SYM_PM   = 8'hB1;
    localparam logic [7:0] CTRL_XOR = 8'h40;

    logic [1:0] fcnt_reg, fcnt_next;
    logic       fcaret_reg, fcaret_next;
    logic [3:0][7:0] eb;
    logic [1:0] ne;
    logic [7:0] b, lo, up;
    logic       accept;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign b      = in_data.in_byte;

    always_comb
    begin
        eb          = '0;
        ne          = 2'd0;
        fcnt_next   = fcnt_reg;
        fcaret_next = fcaret_reg;
        lo = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
        case (fcnt_reg)
            2'd1:
            begin
                fcnt_next = 2'd0;
                if (fcaret_reg)
                begin
                    eb[ne] = (b == CH_SPACE) ? CH_CARET : (up ^ CTRL_XOR);
                    ne = ne + 2'd1;
                end
                else if (b == CH_PCT)
                begin
                    fcnt_next = 2'd2;
                end
                else
                begin
                    eb[ne] = CH_PCT;
                    ne = ne + 2'd1;
                    if (b == CH_CARET || b == CH_PCT)
                    begin
                        fcnt_next   = 2'd1;
                        fcaret_next = (b == CH_CARET);
                    end
                    else
                    begin
                        eb[ne] = b;
                        ne = ne + 2'd1;
                    end
                end
            end
            2'd2:
            begin
                fcnt_next = 2'd0;
                if (lo == 8'h63)
                begin
                    eb[0] = SYM_DIA0;
                    eb[1] = SYM_DIA1;
                    eb[2] = SYM_DIA2;
                    ne = 2'd3;
                end
                else if (lo == 8'h64)
                begin
                    eb[0] = SYM_LEAD;
                    eb[1] = SYM_DEG;
                    ne = 2'd2;
                end
                else if (lo == 8'h70)
                begin
                    eb[0] = SYM_LEAD;
                    eb[1] = SYM_PM;
                    ne = 2'd2;
                end
                else if (!mtext && (lo == 8'h75 || lo == 8'h6F || lo == 8'h6B))
                begin
                    ne = 2'd0;
                end
                else
                begin
                    // The first percent goes out and the second one is reconsidered.
                    eb[ne] = CH_PCT;
                    ne = ne + 2'd1;
                    if (b == CH_PCT)
                    begin
                        fcnt_next = 2'd2;
                    end
                    else
                    begin
                        eb[ne] = CH_PCT;
                        ne = ne + 2'd1;
                        if (b == CH_CARET)
                        begin
                            fcnt_next   = 2'd1;
                            fcaret_next = 1'b1;
                        end
                        else
                        begin
                            eb[ne] = b;
                            ne = ne + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                fcnt_next = 2'd0;
                if (b == CH_CARET || b == CH_PCT)
                begin
                    fcnt_next   = 2'd1;
                    fcaret_next = (b == CH_CARET);
                end
                else
                begin
                    eb[ne] = b;
                    ne = ne + 2'd1;
                end
            end
        endcase
        if (in_data.text_last)
        begin
            if (fcnt_next == 2'd1)
            begin
                eb[ne] = fcaret_next ? CH_CARET : CH_PCT;
                ne = ne + 2'd1;
            end
            else if (fcnt_next == 2'd2)
            begin
                eb[ne] = CH_PCT;
                ne = ne + 2'd1;
                eb[ne] = CH_PCT;
                ne = ne + 2'd1;
            end
            fcnt_next = 2'd0;
        end
    end

    assign q_wr.valid      = accept;
    assign q_wr.data.bytes = eb[2:0];
    assign q_wr.data.n     = ne;
    assign q_wr.data.last  = in_data.text_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg   <= 2'd0;
            fcaret_reg <= 1'b0;
        end
        else if (accept)
        begin
            fcnt_reg   <= fcnt_next;
            fcaret_reg <= fcaret_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dtu_queue.sv =====
// Short queue of pass-one bundles between the front and the back.
`default_nettype none
module dtu_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtu_pkg::bundle_beat_t wr,
    output logic                  full,
    output logic                  rd_valid,
    output dtu_pkg::bundle_t      rd_data,
    input  logic                  rd_en
);
    import dtu_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    logic [AW:0] wp_reg, rp_reg;
    bundle_t     mem_reg [QDEPTH];
    logic [AW:0] occ;

    assign occ      = wp_reg - rp_reg;
    assign full     = (occ == (AW + 1)'(QDEPTH));
    assign rd_valid = (occ != '0);
    assign rd_data  = mem_reg[rp_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr.valid)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
            mem_reg[wp_reg[AW-1:0]] <= wr.data;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dtu_back.sv =====
// Pass two (rich-text codes), end-of-text replay and the result queue.
`default_nettype none
`include "drawing_text_unescape_core_macros.svh"
module dtu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mtext,
    input  logic               rd_valid,
    input  dtu_pkg::bundle_t   rd_data,
    output logic               rd_en,
    output logic               empty,
    input  logic               pop,
    output dtu_pkg::out_item_t out_data
);
    import dtu_pkg::*;

    localparam int AW = $clog2(ODEPTH);

    typedef enum logic [1:0] {
        M_NORMAL    = 2'd0,
        M_ARG       = 2'd1,
        M_STACK     = 2'd2,
        M_STACK_ESC = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t           m;
        logic [2:0]      c;
        logic [2:0][7:0] h;
        logic [2:0][7:0] o;
        logic [1:0]      no;
    } p2_res_t;

    function automatic logic [4:0] hexd(input logic [7:0] x);
        logic [4:0] r;
        r = 5'd0;
        if (x >= 8'h30 && x <= 8'h39)
            r = {1'b1, 4'(x - 8'h30)};
        else if (x >= 8'h61 && x <= 8'h66)
            r = {1'b1, 4'(x - 8'h57)};
        else if (x >= 8'h41 && x <= 8'h46)
            r = {1'b1, 4'(x - 8'h37)};
        return r;
    endfunction

    function automatic logic is_arg(input logic [7:0] x);
        return x == 8'h57 || x == 8'h54 || x == 8'h41 || x == 8'h48 || x == 8'h46 ||
               x == 8'h66 || x == 8'h43 || x == 8'h63 || x == 8'h51 || x == 8'h70;
    endfunction

    function automatic logic is_nul(input logic [7:0] x);
        return x == 8'h4B || x == 8'h6B || x == 8'h4C || x == 8'h6C ||
               x == 8'h4F || x == 8'h6F;
    endfunction

    function automatic logic is_stk(input logic [7:0] x);
        return x == CH_CARET || x == CH_SLASH || x == CH_HASH || x == CH_TILDE;
    endfunction

    function automatic p2_res_t p2_step(input logic [7:0] b, input mode_t m,
                                        input logic [2:0] c, input logic [2:0][7:0] h);
        p2_res_t r;
        logic [4:0] d0, d1, d2, d3;
        logic [15:0] v;
        r.m  = m;
        r.c  = c;
        r.h  = h;
        r.o  = '0;
        r.no = 2'd0;
        d0 = hexd(h[0]);
        d1 = hexd(h[1]);
        d2 = hexd(h[2]);
        d3 = hexd(b);
        if (!d0[4])
            v = 16'd0;
        else if (!d1[4])
            v = {12'd0, d0[3:0]};
        else if (!d2[4])
            v = {8'd0, d0[3:0], d1[3:0]};
        else if (!d3[4])
            v = {4'd0, d0[3:0], d1[3:0], d2[3:0]};
        else
            v = {d0[3:0], d1[3:0], d2[3:0], d3[3:0]};
        case (m)
            M_ARG:
            begin
                if (b == CH_SEMI)
                    r.m = M_NORMAL;
            end
            M_STACK_ESC:
            begin
                r.m = M_STACK;
                if (is_stk(b))
                begin
                    r.o[r.no] = b;
                    r.no = r.no + 2'd1;
                end
                else
                begin
                    r.o[r.no] = CH_BSLASH;
                    r.no = r.no + 2'd1;
                    if (b == CH_SEMI)
                        r.m = M_NORMAL;
                    else if (b == CH_BSLASH)
                        r.m = M_STACK_ESC;
                    else
                    begin
                        r.o[r.no] = b;
                        r.no = r.no + 2'd1;
                    end
                end
            end
            M_STACK:
            begin
                if (b == CH_SEMI)
                    r.m = M_NORMAL;
                else if (b == CH_BSLASH)
                    r.m = M_STACK_ESC;
                else if (!is_stk(b))
                begin
                    r.o[r.no] = b;
                    r.no = r.no + 2'd1;
                end
            end
            default:
            begin
                r.m = M_NORMAL;
                case (c)
                    3'd1:
                    begin
                        r.c = 3'd0;
                        if (b == CH_UPPER_P)
                        begin
                            r.o[r.no] = CH_NL;
                            r.no = r.no + 2'd1;
                        end
                        else if (b == CH_TILDE)
                        begin
                            r.o[r.no] = CH_SPACE;
                            r.no = r.no + 2'd1;
                        end
                        else if (b == CH_UPPER_U)
                            r.c = 3'd2;
                        else if (is_arg(b))
                            r.m = M_ARG;
                        else if (is_nul(b))
                            r.c = 3'd0;
                        else if (b == CH_UPPER_S)
                            r.m = M_STACK;
                        else if (b == CH_BSLASH || b == CH_LBRACE || b == CH_RBRACE)
                        begin
                            r.o[r.no] = b;
                            r.no = r.no + 2'd1;
                        end
                        else
                        begin
                            r.o[r.no] = CH_BSLASH;
                            r.no = r.no + 2'd1;
                            if (b == CH_BSLASH)
                                r.c = 3'd1;
                            else if (b != CH_LBRACE && b != CH_RBRACE)
                            begin
                                r.o[r.no] = b;
                                r.no = r.no + 2'd1;
                            end
                        end
                    end
                    3'd2:
                    begin
                        if (b == CH_PLUS)
                            r.c = 3'd3;
                        else
                        begin
                            r.c = 3'd0;
                            r.o[r.no] = CH_BSLASH;
                            r.no = r.no + 2'd1;
                            r.o[r.no] = CH_UPPER_U;
                            r.no = r.no + 2'd1;
                            if (b == CH_BSLASH)
                                r.c = 3'd1;
                            else if (b != CH_LBRACE && b != CH_RBRACE)
                            begin
                                r.o[r.no] = b;
                                r.no = r.no + 2'd1;
                            end
                        end
                    end
                    3'd3, 3'd4, 3'd5:
                    begin
                        r.h[c[1:0] + 2'd1] = b;
                        r.c = c + 3'd1;
                    end
                    3'd6:
                    begin
                        r.c = 3'd0;
                        if (v == 16'd0)
                            r.no = 2'd0;
                        else if (v[15:7] == 9'd0)
                        begin
                            r.o[0] = v[7:0];
                            r.no = 2'd1;
                        end
                        else if (v[15:11] == 5'd0)
                        begin
                            r.o[0] = {3'b110, v[10:6]};
                            r.o[1] = {2'b10, v[5:0]};
                            r.no = 2'd2;
                        end
                        else
                        begin
                            r.o[0] = {4'b1110, v[15:12]};
                            r.o[1] = {2'b10, v[11:6]};
                            r.o[2] = {2'b10, v[5:0]};
                            r.no = 2'd3;
                        end
                    end
                    default:
                    begin
                        r.c = 3'd0;
                        if (b == CH_BSLASH)
                            r.c = 3'd1;
                        else if (b != CH_LBRACE && b != CH_RBRACE)
                        begin
                            r.o[r.no] = b;
                            r.no = r.no + 2'd1;
                        end
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    mode_t           mode_reg, mode_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0][7:0] hex_reg, hex_next;
    logic [2:0][7:0] stg_reg, stg_next;
    logic [1:0]      stg_n_reg, stg_n_next;
    logic            stg_end_reg, stg_end_next;
    logic            stg_te_reg, stg_te_next;
    logic [4:0][7:0] rep_reg, rep_next;
    logic [2:0]      rep_len_reg, rep_len_next;
    logic [2:0]      rep_idx_reg, rep_idx_next;
    logic            rep_act_reg, rep_act_next;
    logic [1:0]      bidx_reg, bidx_next;
    logic            any_reg, any_next;
    logic [AW:0]     wp_reg, cp_reg, rp_reg;
    logic [AW:0]     wp_next, cp_next, tail;
    logic [AW:0]     hid_cnt;
    out_item_t       ob_reg [ODEPTH];

    p2_res_t         res;
    logic            has_b, fin, ilast, from_rep, src_ok, endi;
    logic [7:0]      sb;
    logic [3:0][7:0] lst;
    logic [2:0]      nl, nl_m1, len_tmp;
    logic            do_write, do_flag, flag_te, end_item, take_b, go, ofull;
    out_item_t       w_item;

    assign ofull   = ((wp_reg - rp_reg) == (AW + 1)'(ODEPTH));
    assign tail    = wp_reg - 1'b1;
    assign hid_cnt = wp_reg - cp_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        hex_next     = hex_reg;
        stg_next     = stg_reg;
        stg_n_next   = stg_n_reg;
        stg_end_next = stg_end_reg;
        stg_te_next  = stg_te_reg;
        rep_next     = rep_reg;
        rep_len_next = rep_len_reg;
        rep_idx_next = rep_idx_reg;
        rep_act_next = rep_act_reg;
        bidx_next    = bidx_reg;
        do_write = 1'b0;
        do_flag  = 1'b0;
        flag_te  = 1'b0;
        end_item = 1'b0;
        take_b   = 1'b0;
        w_item   = '0;
        res.m  = mode_reg;
        res.c  = cnt_reg;
        res.h  = hex_reg;
        res.o  = '0;
        res.no = 2'd0;
        has_b = 1'b0;
        fin = 1'b0;
        ilast = 1'b0;
        from_rep = 1'b0;
        src_ok = 1'b0;
        endi = 1'b0;
        sb = 8'd0;
        lst = '0;
        nl = 3'd0;
        nl_m1 = 3'd0;
        len_tmp = 3'd0;
        if (stg_n_reg != 2'd0)
        begin
            do_write          = 1'b1;
            w_item.out_byte   = stg_reg[0];
            w_item.byte_valid = 1'b1;
            w_item.run_last   = (stg_n_reg == 2'd1) && stg_end_reg;
            w_item.text_end   = w_item.run_last && stg_te_reg;
            end_item          = w_item.run_last;
            stg_next[0] = stg_reg[1];
            stg_next[1] = stg_reg[2];
            stg_n_next  = stg_n_reg - 2'd1;
        end
        else
        begin
            if (rep_act_reg)
            begin
                src_ok   = 1'b1;
                from_rep = 1'b1;
                sb       = rep_reg[rep_idx_reg];
                has_b    = 1'b1;
                fin      = (rep_idx_reg == rep_len_reg - 3'd1);
                ilast    = 1'b1;
            end
            else if (rd_valid)
            begin
                src_ok = 1'b1;
                sb     = rd_data.bytes[bidx_reg];
                has_b  = (rd_data.n != 2'd0);
                fin    = (rd_data.n == 2'd0) || (bidx_reg == rd_data.n - 2'd1);
                ilast  = rd_data.last;
            end
            if (src_ok)
            begin
                if (has_b)
                begin
                    if (mtext)
                        res = p2_step(sb, mode_reg, cnt_reg, hex_reg);
                    else
                    begin
                        res.o[0] = sb;
                        res.no   = 2'd1;
                    end
                end
                lst[2:0] = res.o;
                nl = {1'b0, res.no};
                if (fin && ilast)
                begin
                    // A held escape prefix at text end is replayed as plain text.
                    if (mtext && res.m == M_NORMAL && res.c >= 3'd2)
                    begin
                        lst[nl[1:0]] = CH_BSLASH;
                        nl = nl + 3'd1;
                        rep_next = {res.h[2], res.h[1], res.h[0], CH_PLUS, CH_UPPER_U};
                        len_tmp = res.c - 3'd1;
                        rep_len_next = len_tmp;
                        rep_idx_next = 3'd0;
                        rep_act_next = 1'b1;
                        res.c = 3'd0;
                    end
                    else
                    begin
                        endi = 1'b1;
                        res.m = M_NORMAL;
                        res.c = 3'd0;
                        rep_act_next = 1'b0;
                    end
                end
                else if (fin)
                    endi = 1'b1;
                if (from_rep && !fin)
                    rep_idx_next = rep_idx_reg + 3'd1;
                if (!from_rep)
                begin
                    if (fin)
                    begin
                        bidx_next = 2'd0;
                        take_b    = 1'b1;
                    end
                    else
                        bidx_next = bidx_reg + 2'd1;
                end
                mode_next = res.m;
                cnt_next  = res.c;
                hex_next  = res.h;
                if (nl != 3'd0)
                begin
                    do_write          = 1'b1;
                    w_item.out_byte   = lst[0];
                    w_item.byte_valid = 1'b1;
                    w_item.run_last   = endi && (nl == 3'd1);
                    w_item.text_end   = endi && (nl == 3'd1) && ilast;
                    end_item          = endi && (nl == 3'd1);
                    stg_next     = lst[3:1];
                    nl_m1        = nl - 3'd1;
                    stg_n_next   = nl_m1[1:0];
                    stg_end_next = endi;
                    stg_te_next  = endi && ilast;
                end
                else if (endi)
                begin
                    end_item = 1'b1;
                    if (any_reg)
                    begin
                        do_flag = 1'b1;
                        flag_te = ilast;
                    end
                    else if (ilast)
                    begin
                        do_write        = 1'b1;
                        w_item.run_last = 1'b1;
                        w_item.text_end = 1'b1;
                    end
                end
            end
        end
        go = !(do_write && ofull);
        wp_next  = wp_reg + {{AW{1'b0}}, do_write};
        // An entry stays hidden until the next beat of its item or the item's end.
        cp_next  = end_item ? wp_next : (do_write ? wp_reg : cp_reg);
        any_next = end_item ? 1'b0 : (any_reg || (do_write && w_item.byte_valid));
    end

    assign rd_en    = go && take_b;
    assign empty    = (cp_reg == rp_reg);
    assign out_data = ob_reg[rp_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_NORMAL;
            cnt_reg     <= 3'd0;
            stg_n_reg   <= 2'd0;
            stg_end_reg <= 1'b0;
            stg_te_reg  <= 1'b0;
            rep_len_reg <= 3'd0;
            rep_idx_reg <= 3'd0;
            rep_act_reg <= 1'b0;
            bidx_reg    <= 2'd0;
            any_reg     <= 1'b0;
            wp_reg      <= '0;
            cp_reg      <= '0;
            rp_reg      <= '0;
        end
        else
        begin
            if (go)
            begin
                mode_reg    <= mode_next;
                cnt_reg     <= cnt_next;
                stg_n_reg   <= stg_n_next;
                stg_end_reg <= stg_end_next;
                stg_te_reg  <= stg_te_next;
                rep_len_reg <= rep_len_next;
                rep_idx_reg <= rep_idx_next;
                rep_act_reg <= rep_act_next;
                bidx_reg    <= bidx_next;
                any_reg     <= any_next;
                wp_reg      <= wp_next;
                cp_reg      <= cp_next;
            end
            if (pop && !empty)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hex_reg <= hex_next;
            stg_reg <= stg_next;
            rep_reg <= rep_next;
            if (do_write)
                ob_reg[wp_reg[AW-1:0]] <= w_item;
            if (do_flag)
            begin
                ob_reg[tail[AW-1:0]].run_last <= 1'b1;
                ob_reg[tail[AW-1:0]].text_end <= flag_te;
            end
        end
    end

    `DTU_ASSERT_IMPLY(a_one_hidden, clk, rst_n, 1'b1, hid_cnt <= (AW + 1)'(1))
    `DTU_ASSERT_IMPLY(a_any_hidden, clk, rst_n, any_reg, wp_reg != cp_reg)
    `DTU_ASSERT_NEXT(a_stage_hold, clk, rst_n, (stg_n_reg != 2'd0) && ofull, $stable(stg_n_reg))
    `DTU_ASSERT_IMPLY(a_rep_range, clk, rst_n, rep_act_reg, rep_idx_reg < rep_len_reg)
endmodule
`default_nettype wire

// ===== hw/rtl/drawing_text_unescape_core.sv =====
// Visibility: a result becomes visible in the cycle after the beat that produced its last byte.
// Throughput: one input beat per cycle while each beat yields at most one byte and
// the result queue is not full; every extra byte of a beat holds back the pass-two unit,
// and an escape prefix left open at text end holds it back while its bytes are replayed.
// Reset: rst_n clears both queues, both pass states and mtext_reg asynchronously.
// Top level of the drawing text unescape block.
`default_nettype none
module drawing_text_unescape_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  dtu_pkg::in_item_t  in_data,
    output logic               empty,
    input  logic               pop,
    output dtu_pkg::out_item_t out_data,
    input  logic               mtext_we,
    input  logic               mtext_wdata
);
    import dtu_pkg::*;

    logic         mtext_reg;
    logic         q_full, rd_valid, rd_en;
    bundle_beat_t q_wr;
    bundle_t      rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mtext_reg <= 1'b0;
        else if (mtext_we)
            mtext_reg <= mtext_wdata;
    end

    dtu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_data (in_data),
        .mtext   (mtext_reg),
        .q_full  (q_full),
        .full    (full),
        .q_wr    (q_wr)
    );

    dtu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .full     (q_full),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rd_en    (rd_en)
    );

    dtu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mtext    (mtext_reg),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );
endmodule
`default_nettype wire
